FILE: rtl/core/fdhm_pkg.sv
// ----------------------------------------------------------------------------
// fdhm_pkg: shared definitions for the fault debounce hysteresis monitor
// Field widths, operation and event codes, controller states and the layout
// of one channel's entry in the state memory.
// ----------------------------------------------------------------------------
package fdhm_pkg;

  localparam int CHANNELS    = 16;
  localparam int CHAN_BITS   = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int DEB_BITS    = 16;
  localparam int SEV_BITS    = 2;
  localparam int TOTAL_BITS  = 32;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [SEV_BITS-1:0]   SEV_RESET_LEVEL = 2'd3;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CONFIG = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_RAISE = 2'd1,
    EV_CLEAR = 2'd2
  } event_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_CALC = 1'b1
  } state_t;

  // One channel's stored state
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raise_limit;
    logic [SAMPLE_BITS-1:0] clear_limit;
    logic [COUNT_BITS-1:0]  needed_count;
    logic [COUNT_BITS-1:0]  over_count;
    logic                   is_active;
    logic [SEV_BITS-1:0]    level;
  } chan_entry_t;

  localparam chan_entry_t ENTRY_RESET = '{
    raise_limit:  '0,
    clear_limit:  '0,
    needed_count: COUNT_BITS'(1),
    over_count:   '0,
    is_active:    1'b0,
    level:        SEV_RESET_LEVEL
  };

  // Accepted input transaction held while the entry is read
  typedef struct packed {
    logic                   op;
    logic [CHAN_BITS-1:0]   channel;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SEV_BITS-1:0]    severity;
    logic [SAMPLE_BITS-1:0] high_limit;
    logic [SAMPLE_BITS-1:0] low_limit;
    logic [DEB_BITS-1:0]    debounce_length;
    logic                   in_range;
  } req_t;

endpackage

FILE: rtl/core/fdhm_in_if.sv
// ----------------------------------------------------------------------------
// fdhm_in_if: input channel of the fault debounce hysteresis monitor
// Valid/ready channel carrying one update or configure transaction.
// ----------------------------------------------------------------------------
interface fdhm_in_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [fdhm_pkg::CHAN_BITS-1:0]   channel;
  logic [fdhm_pkg::SAMPLE_BITS-1:0] sample;
  logic [fdhm_pkg::SEV_BITS-1:0]    severity;
  logic [fdhm_pkg::SAMPLE_BITS-1:0] high_limit;
  logic [fdhm_pkg::SAMPLE_BITS-1:0] low_limit;
  logic [fdhm_pkg::DEB_BITS-1:0]    debounce_length;

  modport source (
    output valid, op, channel, sample, severity, high_limit, low_limit,
           debounce_length,
    input  ready
  );

  modport sink (
    input  valid, op, channel, sample, severity, high_limit, low_limit,
           debounce_length,
    output ready
  );
endinterface

FILE: rtl/core/fdhm_out_if.sv
// ----------------------------------------------------------------------------
// fdhm_out_if: result channel of the fault debounce hysteresis monitor
// Valid/ready channel carrying one result transaction per input transaction.
// ----------------------------------------------------------------------------
interface fdhm_out_if;
  logic                            valid;
  logic                            ready;
  logic                            status;
  logic [1:0]                      event_res;
  logic [fdhm_pkg::CHAN_BITS-1:0]  event_channel;
  logic [fdhm_pkg::SEV_BITS-1:0]   event_severity;
  logic                            fault_active;
  logic [fdhm_pkg::TOTAL_BITS-1:0] update_total;

  modport source (
    output valid, status, event_res, event_channel, event_severity,
           fault_active, update_total,
    input  ready
  );

  modport sink (
    input  valid, status, event_res, event_channel, event_severity,
           fault_active, update_total,
    output ready
  );
endinterface

FILE: rtl/core/fault_debounce_hysteresis_monitor.sv
// ----------------------------------------------------------------------------
// fault_debounce_hysteresis_monitor: multi-channel debounced fault qualifier
// Per-channel limits, debounce count and active flag live in one synchronous
// memory; each transaction reads its channel's entry, updates it, writes back.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  (sink)  : update (op 0, sample) or configure (op 1, severity,
//                    limits, debounce length) transaction for one channel.
//   out_if (source): exactly one result per input transaction, in order:
//                    status, event, channel, severity, active flag and the
//                    running update count.
// Flow: a new transaction is taken only after the previous one is evaluated.
//   The accept cycle reads the channel entry from the state memory into a
//   register; the evaluate state then checks the entry, writes it back and
//   loads the output register that presents the result.
// Stall: the output register holds a finished result while the next input
//   transaction is accepted and read; evaluation then waits until the
//   output register is taken, and input ready stays low meanwhile.
// Reset: rst_n (synchronous, active low) clears the update count, the
//   output valid and the per-entry valid bits; an entry never written reads
//   as limits 0, debounce length 1, count 0, inactive, severity critical.
//   No clearing pass is needed, the block is ready right after reset.
// ----------------------------------------------------------------------------
module fault_debounce_hysteresis_monitor (
  input logic       clk,
  input logic       rst_n,
  fdhm_in_if.sink   in_if,
  fdhm_out_if.source out_if
);

  // State memory and its per-entry valid bits
  fdhm_pkg::chan_entry_t mem [fdhm_pkg::CHANNELS];
  logic [fdhm_pkg::CHANNELS-1:0] vld_r;

  fdhm_pkg::state_t state_r, state_nxt;
  fdhm_pkg::req_t   req_r;
  fdhm_pkg::chan_entry_t rdata_r;
  logic             rvld_r;

  logic [fdhm_pkg::TOTAL_BITS-1:0] upd_r, upd_nxt;

  logic                              out_vld_r;
  logic                              out_status_r;
  fdhm_pkg::event_t                  out_event_r;
  logic [fdhm_pkg::CHAN_BITS-1:0]    out_chan_r;
  logic [fdhm_pkg::SEV_BITS-1:0]     out_sev_r;
  logic                              out_active_r;
  logic [fdhm_pkg::TOTAL_BITS-1:0]   out_total_r;

  logic                   in_fire;
  logic                   in_range;
  logic                   out_free;
  logic                   wr_en;
  logic                   load_out;
  fdhm_pkg::chan_entry_t  ent;
  fdhm_pkg::chan_entry_t  wdata;
  fdhm_pkg::event_t       ev;
  logic [fdhm_pkg::COUNT_BITS-1:0] cnt_inc;
  logic [fdhm_pkg::COUNT_BITS-1:0] need_cfg;
  logic [fdhm_pkg::DEB_BITS-1:0]   deb_nz;
  logic                   at_raise;
  logic                   at_clear;

  assign in_range = ({1'b0, in_if.channel} < (fdhm_pkg::CHAN_BITS + 1)'(fdhm_pkg::CHANNELS));
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_free = !out_vld_r || out_if.ready;

  // Latch the request and read its channel entry
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= '{
        op:              in_if.op,
        channel:         in_if.channel,
        sample:          in_if.sample,
        severity:        in_if.severity,
        high_limit:      in_if.high_limit,
        low_limit:       in_if.low_limit,
        debounce_length: in_if.debounce_length,
        in_range:        in_range
      };
      if (in_range) begin
        rdata_r <= mem[in_if.channel];
        rvld_r  <= vld_r[in_if.channel];
      end else begin
        rvld_r  <= 1'b0;
      end
    end
  end

  // Write back the modified entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[req_r.channel] <= wdata;
    end
  end

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[req_r.channel] <= 1'b1;
    end
  end

  // Evaluate the entry against the sample or the new configuration
  always_comb begin
    ent      = rvld_r ? rdata_r : fdhm_pkg::ENTRY_RESET;
    deb_nz   = (req_r.debounce_length == '0) ? fdhm_pkg::DEB_BITS'(1) : req_r.debounce_length;
    need_cfg = (32'(deb_nz) > 32'(fdhm_pkg::CNT_MAX)) ? fdhm_pkg::CNT_MAX
                                                       : fdhm_pkg::COUNT_BITS'(deb_nz);
    cnt_inc  = (ent.over_count == fdhm_pkg::CNT_MAX) ? ent.over_count
                                                     : ent.over_count + 1'b1;
    at_raise = $signed(req_r.sample) >= $signed(ent.raise_limit);
    at_clear = $signed(req_r.sample) <= $signed(ent.clear_limit);
    wdata    = ent;
    ev       = fdhm_pkg::EV_NONE;
    upd_nxt  = upd_r;

    if (req_r.op == fdhm_pkg::OP_CONFIG) begin
      wdata.raise_limit  = req_r.high_limit;
      wdata.clear_limit  = req_r.low_limit;
      wdata.needed_count = need_cfg;
      wdata.over_count   = '0;
      wdata.is_active    = 1'b0;
      wdata.level        = req_r.severity;
    end else begin
      upd_nxt = upd_r + 1'b1;
      if (at_raise) begin
        wdata.over_count = cnt_inc;
        if (!ent.is_active && (cnt_inc >= ent.needed_count)) begin
          wdata.is_active = 1'b1;
          ev              = fdhm_pkg::EV_RAISE;
        end
      end else if (at_clear) begin
        wdata.over_count = '0;
        if (ent.is_active) begin
          wdata.is_active = 1'b0;
          ev              = fdhm_pkg::EV_CLEAR;
        end
      end else begin
        wdata.over_count = '0;
      end
    end

    // Out-of-range channel leaves all state alone
    if (!req_r.in_range) begin
      ev      = fdhm_pkg::EV_NONE;
      upd_nxt = upd_r;
    end
  end

  // Sequence read, evaluate and hand off
  always_comb begin
    state_nxt   = state_r;
    in_if.ready = 1'b0;
    load_out    = 1'b0;
    wr_en       = 1'b0;
    case (state_r)
      fdhm_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          state_nxt = fdhm_pkg::ST_CALC;
        end
      end
      fdhm_pkg::ST_CALC: begin
        if (out_free) begin
          load_out  = 1'b1;
          wr_en     = req_r.in_range;
          state_nxt = fdhm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fdhm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fdhm_pkg::ST_IDLE;
      upd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        upd_r <= upd_nxt;
      end
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= !req_r.in_range;
      out_event_r  <= ev;
      out_chan_r   <= req_r.channel;
      out_sev_r    <= req_r.in_range ? wdata.level : '0;
      out_active_r <= req_r.in_range && wdata.is_active;
      out_total_r  <= upd_nxt;
    end
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.status         = out_status_r;
  assign out_if.event_res      = out_event_r;
  assign out_if.event_channel  = out_chan_r;
  assign out_if.event_severity = out_sev_r;
  assign out_if.fault_active   = out_active_r;
  assign out_if.update_total   = out_total_r;

`ifndef SYNTHESIS
  // An accepted transaction always moves to evaluation
  a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == fdhm_pkg::ST_CALC)
    else $error("accepted transaction did not enter evaluation");

  // A raise event reports the channel as active
  a_raise_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.event_res == fdhm_pkg::EV_RAISE) |-> out_if.fault_active)
    else $error("raise event without active flag");

  // The update count advances by at most one per result
  a_upd_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (upd_r != $past(upd_r)) |-> (upd_r == $past(upd_r) + 1'b1)
      && $past(load_out))
    else $error("update count moved without a result");

  // A result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_vld_r || out_if.ready))
    else $error("pending result overwritten");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fault_debounce_hysteresis_monitor
// Drives update and configure transactions through the input channel,
// predicts every result with a local model of the per-channel debounce and
// hysteresis state, and compares each result field by field. Directed
// corners come first, then a long debounce run, a long output hold-off,
// and random per-channel sequences with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import fdhm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 1000;

  typedef struct {
    op_t                           op;
    logic [CHAN_BITS-1:0]          channel;
    logic [SAMPLE_BITS-1:0]        sample;
    logic [SEV_BITS-1:0]           severity;
    logic [SAMPLE_BITS-1:0]        high_limit;
    logic [SAMPLE_BITS-1:0]        low_limit;
    logic [DEB_BITS-1:0]           debounce_length;
  } fault_req_t;

  typedef struct {
    logic                  status;
    event_t                ev_code;
    logic [CHAN_BITS-1:0]  channel;
    logic [SEV_BITS-1:0]   severity;
    logic                  active;
    logic [TOTAL_BITS-1:0] total;
  } fault_result_t;

  logic clk;
  logic rst_n;

  fdhm_in_if  in_ch ();
  fdhm_out_if out_ch ();

  fault_debounce_hysteresis_monitor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Local copy of the per-channel qualifier state
  logic signed [SAMPLE_BITS-1:0] raise_tbl  [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] clear_tbl  [CHANNELS];
  logic [COUNT_BITS-1:0]         needed_tbl [CHANNELS];
  logic [COUNT_BITS-1:0]         over_tbl   [CHANNELS];
  logic                          active_tbl [CHANNELS];
  logic [SEV_BITS-1:0]           sev_tbl    [CHANNELS];
  logic [TOTAL_BITS-1:0]         updates_done;

  fault_result_t expected_results [$];

  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned updates_sent;
  int unsigned configs_sent;
  int unsigned raises_seen;
  int unsigned clears_seen;
  bit          idle_on;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned stall_left;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Gap length: mostly none or short, a few long
  function automatic int unsigned next_gap();
    int unsigned p;
    if (!idle_on) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Qualify one transaction against the channel state, return its result
  function automatic fault_result_t qualify_item(fault_req_t it);
    fault_result_t                 r;
    logic signed [SAMPLE_BITS-1:0] s;
    int unsigned                   ch;
    ch        = it.channel;
    r.status  = 1'b0;
    r.ev_code = EV_NONE;
    r.channel = it.channel;
    r.severity = '0;
    r.active  = 1'b0;
    r.total   = updates_done;
    if (ch >= CHANNELS) begin
      r.status = 1'b1;
      return r;
    end
    if (it.op == OP_CONFIG) begin
      configs_sent++;
      sev_tbl[ch]   = it.severity;
      raise_tbl[ch] = it.high_limit;
      clear_tbl[ch] = it.low_limit;
      if (it.debounce_length == 0)
        needed_tbl[ch] = COUNT_BITS'(1);
      else if (it.debounce_length > CNT_MAX)
        needed_tbl[ch] = CNT_MAX;
      else
        needed_tbl[ch] = COUNT_BITS'(it.debounce_length);
      over_tbl[ch]   = '0;
      active_tbl[ch] = 1'b0;
    end else begin
      updates_sent++;
      s = it.sample;
      // Raise test wins when the limits overlap
      if (s >= raise_tbl[ch]) begin
        if (over_tbl[ch] != CNT_MAX) over_tbl[ch]++;
        if (!active_tbl[ch] && over_tbl[ch] >= needed_tbl[ch]) begin
          active_tbl[ch] = 1'b1;
          r.ev_code = EV_RAISE;
          raises_seen++;
        end
      end else if (s <= clear_tbl[ch]) begin
        over_tbl[ch] = '0;
        if (active_tbl[ch]) begin
          active_tbl[ch] = 1'b0;
          r.ev_code = EV_CLEAR;
          clears_seen++;
        end
      end else begin
        over_tbl[ch] = '0;
      end
      updates_done++;
    end
    r.severity = sev_tbl[ch];
    r.active   = active_tbl[ch];
    r.total    = updates_done;
    return r;
  endfunction

  // Send one transaction and record its expected result on acceptance
  task automatic send_item(fault_req_t it);
    int unsigned gap;
    gap = next_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.op              <= it.op;
    in_ch.channel         <= it.channel;
    in_ch.sample          <= it.sample;
    in_ch.severity        <= it.severity;
    in_ch.high_limit      <= it.high_limit;
    in_ch.low_limit       <= it.low_limit;
    in_ch.debounce_length <= it.debounce_length;
    in_ch.valid           <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(qualify_item(it));
    items_sent++;
  endtask

  function automatic fault_req_t make_update(int unsigned ch, int value);
    fault_req_t it;
    it.op              = OP_UPDATE;
    it.channel         = CHAN_BITS'(ch);
    it.sample          = SAMPLE_BITS'(value);
    it.severity        = SEV_BITS'($urandom_range(0, 3));
    it.high_limit      = SAMPLE_BITS'($urandom_range(0, 65535));
    it.low_limit       = SAMPLE_BITS'($urandom_range(0, 65535));
    it.debounce_length = DEB_BITS'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic fault_req_t make_config(int unsigned ch, int unsigned sev, int hi,
                                             int lo, int unsigned deb);
    fault_req_t it;
    it.op              = OP_CONFIG;
    it.channel         = CHAN_BITS'(ch);
    it.sample          = SAMPLE_BITS'($urandom_range(0, 65535));
    it.severity        = SEV_BITS'(sev);
    it.high_limit      = SAMPLE_BITS'(hi);
    it.low_limit       = SAMPLE_BITS'(lo);
    it.debounce_length = DEB_BITS'(deb);
    return it;
  endfunction

  // Configure with random limits, mostly a proper band, sometimes inverted
  function automatic fault_req_t random_config(int unsigned ch);
    int          hi;
    int          lo;
    int unsigned deb;
    int unsigned q;
    lo = int'($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 9) == 0) begin
      hi = lo - int'($urandom_range(0, 500));
      if (hi < -32768) hi = -32768;
    end else begin
      hi = lo + int'($urandom_range(1, 3000));
      if (hi > 32767) hi = 32767;
    end
    q = $urandom_range(0, 9);
    if (q < 7) deb = $urandom_range(0, 6);
    else if (q < 9) deb = $urandom_range(7, 15);
    else deb = $urandom_range(0, 65535);
    return make_config(ch, $urandom_range(0, 3), hi, lo, deb);
  endfunction

  // Sample aimed at one region of a channel's limits: 0 high, 1 low, 2 band
  function automatic int aimed_sample(int unsigned ch, int unsigned region);
    int hi;
    int lo;
    hi = raise_tbl[ch];
    lo = clear_tbl[ch];
    case (region)
      0: begin
        if ($urandom_range(0, 3) == 0) return hi;
        return hi + int'($urandom_range(0, 32767 - hi));
      end
      1: begin
        if ($urandom_range(0, 3) == 0) return lo;
        return lo - int'($urandom_range(0, lo + 32768));
      end
      default: begin
        if (hi - lo > 1) return lo + 1 + int'($urandom_range(0, hi - lo - 2));
        return int'($urandom_range(0, 65535)) - 32768;
      end
    endcase
  endfunction

  function automatic fault_req_t noise_item();
    fault_req_t it;
    it = make_update($urandom_range(0, CHANNELS - 1), int'($urandom_range(0, 65535)));
    if ($urandom_range(0, 3) == 0) it.op = OP_CONFIG;
    return it;
  endfunction

  // Result checker
  always @(posedge clk) begin
    fault_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected, channel %0d",
               out_ch.event_channel);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.event_res !== want.ev_code) begin
          $error("event_res: expected %0d, got %0d", want.ev_code, out_ch.event_res);
          fail_count++;
        end
        if (out_ch.event_channel !== want.channel) begin
          $error("event_channel: expected %0d, got %0d", want.channel,
                 out_ch.event_channel);
          fail_count++;
        end
        if (out_ch.event_severity !== want.severity) begin
          $error("event_severity: expected %0d, got %0d", want.severity,
                 out_ch.event_severity);
          fail_count++;
        end
        if (out_ch.fault_active !== want.active) begin
          $error("fault_active: expected %0d, got %0d", want.active, out_ch.fault_active);
          fail_count++;
        end
        if (out_ch.update_total !== want.total) begin
          $error("update_total: expected %0d, got %0d", want.total, out_ch.update_total);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left = next_gap();
      out_ch.ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Corners after reset: default entries, extreme limits, inverted limits,
  // reconfigure while active, debounce counting and band reset
  task automatic test_directed();
    send_item(make_update(0, 0));
    send_item(make_update(0, 0));
    send_item(make_update(0, -1));
    send_item(make_update(1, -32768));
    send_item(make_config(2, 0, 32767, -32768, 0));
    send_item(make_update(2, 32767));
    send_item(make_update(2, 0));
    send_item(make_update(2, -32768));
    send_item(make_config(3, 1, -32768, 32767, 2));
    send_item(make_update(3, 32767));
    send_item(make_update(3, 32767));
    send_item(make_update(3, -32768));
    send_item(make_config(3, 2, 0, 0, 1));
    send_item(make_config(15, 2, 100, -100, 3));
    send_item(make_update(15, 100));
    send_item(make_update(15, 100));
    send_item(make_update(15, 50));
    send_item(make_update(15, 100));
    send_item(make_update(15, 100));
    send_item(make_update(15, 100));
    send_item(make_update(15, -100));
    send_item(make_update(15, -32768));
  endtask

  // Long debounce: raise on the last count and stay active, then the
  // largest debounce length with a few over-limit samples and no raise
  task automatic test_max_debounce();
    int unsigned i;
    idle_on = 1'b0;
    send_item(make_config(7, 1, -32768, -32768, 40));
    for (i = 0; i < 44; i++)
      send_item(make_update(7, int'($urandom_range(0, 65535)) - 32768));
    send_item(make_config(7, 3, 0, 0, 65535));
    for (i = 0; i < 4; i++)
      send_item(make_update(7, 32767));
    send_item(make_config(7, 3, 0, 0, 0));
    idle_on = 1'b1;
  endtask

  // Hold the output off long enough that the block fills and stalls its input
  task automatic test_backpressure();
    int unsigned i;
    hold_request = 80;
    for (i = 0; i < 12; i++) send_item(noise_item());
  endtask

  // Per-channel sequences with random content, mixed with noise
  task automatic test_random();
    int unsigned stop_at;
    int unsigned ch;
    int unsigned region;
    int unsigned burst;
    int unsigned bursts;
    int unsigned cap;
    int unsigned b;
    int unsigned k;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        send_item(noise_item());
      end else begin
        ch = $urandom_range(0, CHANNELS - 1);
        send_item(random_config(ch));
        bursts = $urandom_range(2, 6);
        for (b = 0; b < bursts; b++) begin
          region = $urandom_range(0, 2);
          cap = (needed_tbl[ch] > 10) ? 12 : needed_tbl[ch] + 2;
          burst = (region == 0) ? $urandom_range(1, cap) : $urandom_range(1, 2);
          for (k = 0; k < burst; k++) begin
            if ($urandom_range(0, 4) == 0) send_item(noise_item());
            send_item(make_update(ch, aimed_sample(ch, region)));
          end
        end
      end
    end
  endtask

  task automatic finish_run();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Checked %0d results: %0d updates, %0d configures across all channels,",
             results_checked, updates_sent, configs_sent);
    $display("with %0d raise and %0d clear events, including a long debounce run.",
             raises_seen, clears_seen);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  endtask

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      raise_tbl[i]  = '0;
      clear_tbl[i]  = '0;
      needed_tbl[i] = COUNT_BITS'(1);
      over_tbl[i]   = '0;
      active_tbl[i] = 1'b0;
      sev_tbl[i]    = SEV_RESET_LEVEL;
    end
    updates_done    = '0;
    cycle_count     = 0;
    fail_count      = 0;
    items_sent      = 0;
    results_checked = 0;
    updates_sent    = 0;
    configs_sent    = 0;
    raises_seen     = 0;
    clears_seen     = 0;
    hold_request    = 0;
    hold_left       = 0;
    stall_left      = 0;
    idle_on         = 1'b1;

    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.op              = 1'b0;
    in_ch.channel         = '0;
    in_ch.sample          = '0;
    in_ch.severity        = '0;
    in_ch.high_limit      = '0;
    in_ch.low_limit       = '0;
    in_ch.debounce_length = '0;
    out_ch.ready          = 1'b0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_max_debounce();
    test_backpressure();
    test_random();
    finish_run();
  end

endmodule
